@@ rtl/core/gio_pkg.sv @@
`default_nettype none
package gio_pkg;

  // Command carried in the input tuser field.
  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_RUN   = 2'd1,
    FN_READ  = 2'd2
  } func_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS     = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RDWAIT = 6'b000010,
    ST_HPASS  = 6'b000100,
    ST_GAP    = 6'b001000,
    ST_VPASS  = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  localparam logic signed [7:0] OBSTACLE_VAL = 8'sd100;
  localparam logic [6:0]        COST_OBST    = 7'd100;
  localparam logic [6:0]        COST_FREE    = 7'd1;
  localparam logic [6:0]        COST_NONE    = 7'd0;

  // Distance counter of the window unit; saturates well above twice the
  // largest radius.
  localparam int DIST_W = 10;

endpackage
`default_nettype wire

@@ rtl/core/gio_ram.sv @@
`default_nettype none
module gio_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/grid_obstacle_inflation_unit.sv @@
`default_nettype none
// Occupancy grid with obstacle inflation. Cells are written and read one per
// input transaction (tuser selects write, run or read); a cell is an obstacle
// only when its written value is exactly 100. A write result is registered
// directly, while a read inside the last run's area waits on the inflated
// map, a RAM with registered read. A run dilates the obstacles by the
// configured radius in two separable passes through one shared window unit:
// a row pass over the occupancy RAM and a column pass over an intermediate
// RAM, each cell a cycle; no input transaction is accepted during a run.
// Reads in the map but outside the area of the last run return the free
// cost, and reads before any run return cost 0. The configuration port is
// always ready; write it only while the unit is idle.
module grid_obstacle_inflation_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [23:0]    in_tdata,   // col[7:0], row[15:8], cell_value[23:16]
  input  wire gio_pkg::func_t in_tuser,   // func[1:0]
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic      [7:0]     out_tdata,  // cost[6:0], zero[7]
  output logic                out_tuser,  // status[0]
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [8:0]     cfg_data
);
  import gio_pkg::*;

  localparam int CB     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RB     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW     = CB + RB;
  localparam int DEPTH  = 1 << AW;
  localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int NW     = $clog2(MAXDIM + 1);
  localparam int TW     = $clog2(MAXDIM + 256);
  localparam int OW     = (MAXDIM > 1) ? $clog2(MAXDIM) : 1;
  localparam int CW     = (NW > 8) ? NW : 8;
  localparam int SW     = (NW > 9) ? NW : 9;

  state_t            state_r, state_nxt;
  logic [8:0]        map_width_r, map_width_nxt;
  logic [8:0]        map_height_r, map_height_nxt;
  logic [7:0]        radius_r, radius_nxt;
  logic [NW-1:0]     run_w_r, run_w_nxt;
  logic [NW-1:0]     run_h_r, run_h_nxt;
  logic              infl_valid_r, infl_valid_nxt;
  logic [OW-1:0]     o_r, o_nxt;
  logic [TW-1:0]     t_r, t_nxt;
  logic              s1_vld_r, s1_vpass_r, s1_in_r;
  logic [TW-1:0]     s1_t_r;
  logic [OW-1:0]     s1_o_r;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              seen_r, seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_cost_r, out_cost_nxt;
  logic              out_status_r, out_status_nxt;

  logic [7:0]        in_col, in_row;
  logic signed [7:0] in_val;
  logic [NW-1:0]     used_w, used_h;
  logic              in_range, in_run_region, out_free, in_fire;
  logic [AW-1:0]     in_addr;
  logic              issue, issue_in, row_end, pass_last;
  logic [NW-1:0]     n_outer, n_inner;
  logic [TW-1:0]     t_last;
  logic              s1_bit, s1_start, s1_out, hit;
  logic [TW-1:0]     s1_p;

  logic              occ_we, occ_wd, occ_rdata;
  logic [AW-1:0]     occ_wa, occ_ra;
  logic              rg_we, rg_rdata;
  logic [AW-1:0]     rg_wa, rg_ra;
  logic              inf_we, inf_rdata;
  logic [AW-1:0]     inf_wa;

  assign in_col = in_tdata[7:0];
  assign in_row = in_tdata[15:8];
  assign in_val = signed'(in_tdata[23:16]);

  assign used_w = (SW'(map_width_r) > SW'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : NW'(map_width_r);
  assign used_h = (SW'(map_height_r) > SW'(MAX_HEIGHT)) ? NW'(MAX_HEIGHT) :
                  NW'(map_height_r);

  assign in_range      = (CW'(in_col) < CW'(used_w)) && (CW'(in_row) < CW'(used_h));
  assign in_run_region = (CW'(in_col) < CW'(run_w_r)) && (CW'(in_row) < CW'(run_h_r));
  assign in_addr       = {RB'(in_row), CB'(in_col)};

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cost_r};
  assign out_tuser  = out_status_r;

  // Pass sequencing: outer index walks rows (row pass) or columns (column
  // pass); inner index runs R cells past the end so the window can close.
  assign n_outer   = (state_r == ST_VPASS) ? run_w_r : run_h_r;
  assign n_inner   = (state_r == ST_VPASS) ? run_h_r : run_w_r;
  assign t_last    = TW'(n_inner) + TW'(radius_r) - TW'(1);
  assign issue     = (state_r == ST_HPASS) || (state_r == ST_VPASS);
  assign issue_in  = t_r < TW'(n_inner);
  assign row_end   = (t_r == t_last);
  assign pass_last = row_end && ((NW'(o_r) + NW'(1)) == n_outer);

  // Shared window unit. Position p = t - R is inflated when an obstacle lies
  // in [t-2R, t], i.e. the distance since the last obstacle is at most 2R.
  assign s1_bit   = s1_in_r && (s1_vpass_r ? rg_rdata : occ_rdata);
  assign s1_start = (s1_t_r == '0);
  assign s1_out   = s1_t_r >= TW'(radius_r);
  assign s1_p     = s1_t_r - TW'(radius_r);

  always_comb begin
    if (s1_bit) begin
      dist_nxt = '0;
      seen_nxt = 1'b1;
    end else begin
      dist_nxt = (&dist_r) ? dist_r : dist_r + DIST_W'(1);
      seen_nxt = !s1_start && seen_r;
    end
    hit = seen_nxt && (dist_nxt <= DIST_W'({radius_r, 1'b0}));
  end

  assign occ_we = in_fire && (in_tuser == FN_WRITE) && in_range;
  assign occ_wa = in_addr;
  assign occ_wd = (in_val == OBSTACLE_VAL);
  assign occ_ra = {RB'(o_r), CB'(t_r)};

  assign rg_we = s1_vld_r && !s1_vpass_r && s1_out;
  assign rg_wa = {RB'(s1_o_r), CB'(s1_p)};
  assign rg_ra = {RB'(t_r), CB'(o_r)};

  assign inf_we = s1_vld_r && s1_vpass_r && s1_out;
  assign inf_wa = {RB'(s1_p), CB'(s1_o_r)};

  gio_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ_ram (
    .clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd),
    .raddr(occ_ra), .rdata(occ_rdata)
  );

  gio_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_row_ram (
    .clk(clk), .we(rg_we), .waddr(rg_wa), .wdata(hit),
    .raddr(rg_ra), .rdata(rg_rdata)
  );

  gio_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_infl_ram (
    .clk(clk), .we(inf_we), .waddr(inf_wa), .wdata(hit),
    .raddr(in_addr), .rdata(inf_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    radius_nxt     = radius_r;
    run_w_nxt      = run_w_r;
    run_h_nxt      = run_h_r;
    infl_valid_nxt = infl_valid_r;
    o_nxt          = o_r;
    t_nxt          = t_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cost_nxt   = out_cost_r;
    out_status_nxt = out_status_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_nxt  = cfg_data;
        CFG_MAP_HEIGHT: map_height_nxt = cfg_data;
        CFG_RADIUS:     radius_nxt     = cfg_data[7:0];
        default:        ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            FN_WRITE: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = !in_range;
              out_cost_nxt   = COST_NONE;
            end
            FN_READ: begin
              if (!in_range || !infl_valid_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = !in_range;
                out_cost_nxt   = COST_NONE;
              end else if (!in_run_region) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b0;
                out_cost_nxt   = COST_FREE;
              end else begin
                state_nxt = ST_RDWAIT;
              end
            end
            FN_RUN: begin
              run_w_nxt = used_w;
              run_h_nxt = used_h;
              o_nxt     = '0;
              t_nxt     = '0;
              if ((used_w == '0) || (used_h == '0)) begin
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_HPASS;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = 1'b0;
              out_cost_nxt   = COST_NONE;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        out_cost_nxt   = inf_rdata ? COST_OBST : COST_FREE;
        state_nxt      = ST_IDLE;
      end
      ST_HPASS, ST_VPASS: begin
        if (row_end) begin
          t_nxt = '0;
          o_nxt = pass_last ? '0 : o_r + OW'(1);
        end else begin
          t_nxt = t_r + TW'(1);
        end
        if (pass_last) begin
          state_nxt = (state_r == ST_HPASS) ? ST_GAP : ST_FIN;
        end
      end
      // An idle state lets the last row-pass write land before the column
      // pass reads the intermediate RAM.
      ST_GAP: begin
        state_nxt = ST_VPASS;
      end
      ST_FIN: begin
        infl_valid_nxt = 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        out_cost_nxt   = COST_NONE;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
      radius_r     <= 8'd0;
      infl_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      s1_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
      radius_r     <= radius_nxt;
      infl_valid_r <= infl_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      s1_vld_r     <= issue;
    end
  end

  always_ff @(posedge clk) begin
    run_w_r      <= run_w_nxt;
    run_h_r      <= run_h_nxt;
    o_r          <= o_nxt;
    t_r          <= t_nxt;
    out_cost_r   <= out_cost_nxt;
    out_status_r <= out_status_nxt;
    s1_vpass_r   <= (state_r == ST_VPASS);
    s1_in_r      <= issue_in;
    s1_t_r       <= t_r;
    s1_o_r       <= o_r;
    if (s1_vld_r) begin
      dist_r <= dist_nxt;
      seen_r <= seen_nxt;
    end
  end

  // The window unit only writes positions inside the map of the current run.
  a_wr_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_out |-> s1_p < TW'(s1_vpass_r ? run_h_r : run_w_r))
    else $error("inflation write outside map");

  // A pending read always produces its result on the next cycle.
  a_rd_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RDWAIT |=> out_valid_r)
    else $error("read result missing");

  // A transaction is never taken while an untaken result would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !out_valid_r || out_tready)
    else $error("result register overrun");

  // Finishing a run marks the inflated map as valid.
  a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |=> infl_valid_r && out_valid_r)
    else $error("run completion not recorded");

endmodule
`default_nettype wire
